// ===== rtl/core/lbc_pkg.sv =====
`default_nettype none

package lbc_pkg;

    localparam int LEDS      = 4;
    localparam int LED_IDX_W = (LEDS > 1) ? $clog2(LEDS) : 1;
    localparam int PIN_W     = 4;
    localparam int POL_W     = 4;
    localparam int PERIOD_W  = 24;
    localparam int TOGGLE_W  = 17;
    localparam int MODE_W    = 2;
    localparam int INDEX_W   = 8;
    localparam int TIMES_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = PERIOD_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BASE = CFG_IDX_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT  = 2'd0,
        MODE_ON    = 2'd1,
        MODE_OFF   = 2'd2,
        MODE_BLINK = 2'd3
    } mode_t;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    typedef struct packed {
        mode_t                mode;
        logic [INDEX_W-1:0]   led_index;
        logic [TIMES_W-1:0]   blink_times;
    } req_t;

    typedef struct packed {
        logic                 status;
        logic [PIN_W-1:0]     pin_levels;
    } rsp_t;

    typedef struct packed {
        logic [POL_W-1:0]               polarity_low;
        logic [LEDS-1:0][PERIOD_W-1:0]  period;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/lbc_req_if.sv =====
`default_nettype none

interface lbc_req_if
    import lbc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    mode_t                mode;
    logic [INDEX_W-1:0]   led_index;
    logic [TIMES_W-1:0]   blink_times;

    modport source (output valid, output mode, output led_index, output blink_times,
                    input ready);
    modport sink   (input valid, input mode, input led_index, input blink_times,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lbc_rsp_if.sv =====
`default_nettype none

interface lbc_rsp_if
    import lbc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic [PIN_W-1:0]     pin_levels;

    modport source (output valid, output status, output pin_levels, input ready);
    modport sink   (input valid, input status, input pin_levels, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lbc_cfg_regs.sv =====
`default_nettype none

module lbc_cfg_regs
    import lbc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    output cfg_t                        cfg
);

    logic [POL_W-1:0]               polarity_reg;
    logic [POL_W-1:0]               polarity_next;
    logic [LEDS-1:0][PERIOD_W-1:0]  period_reg;
    logic [LEDS-1:0][PERIOD_W-1:0]  period_next;

    always_comb
    begin
        polarity_next = polarity_reg;
        period_next   = period_reg;
        if (cfg_we)
        begin
            if (cfg_index == REG_POLARITY)
            begin
                polarity_next = cfg_data[POL_W-1:0];
            end
            for (int i = 0; i < LEDS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(int'(REG_PERIOD_BASE) + i))
                begin
                    period_next[i] = cfg_data[PERIOD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polarity_reg <= '0;
            for (int i = 0; i < LEDS; i++)
            begin
                period_reg[i] <= PERIOD_RESET;
            end
        end
        else
        begin
            polarity_reg <= polarity_next;
            period_reg   <= period_next;
        end
    end

    assign cfg.polarity_low = polarity_reg;
    assign cfg.period       = period_reg;

endmodule

`default_nettype wire

// ===== rtl/core/lbc_led_core.sv =====
`default_nettype none

module lbc_led_core
    import lbc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   step_fire,
    input  req_t        req,
    input  cfg_t        cfg,
    output rsp_t        result
);

    logic [LEDS-1:0][PERIOD_W-1:0]  tick_reg;
    logic [LEDS-1:0][PERIOD_W-1:0]  tick_next;
    logic [LEDS-1:0][TOGGLE_W-1:0]  toggle_reg;
    logic [LEDS-1:0][TOGGLE_W-1:0]  toggle_next;
    logic [LEDS-1:0]                phase_reg;
    logic [LEDS-1:0]                phase_next;
    logic [PIN_W-1:0]               pin_reg;
    logic [PIN_W-1:0]               pin_next;
    logic                           status;
    logic                           bad_index;
    logic [LED_IDX_W-1:0]           sel;
    logic [TOGGLE_W-1:0]            toggle_limit;

    assign sel          = req.led_index[LED_IDX_W-1:0];
    assign bad_index    = req.led_index >= INDEX_W'(LEDS);
    assign toggle_limit = {req.blink_times, 1'b0};

    always_comb
    begin
        tick_next   = tick_reg;
        toggle_next = toggle_reg;
        phase_next  = phase_reg;
        pin_next    = pin_reg;
        status      = STATUS_OK;
        if (req.mode != MODE_INIT && bad_index)
        begin
            status = STATUS_BAD_INDEX;
        end
        else
        begin
            unique case (req.mode)
                MODE_INIT:
                begin
                    for (int i = 0; i < LEDS; i++)
                    begin
                        pin_next[i] = cfg.polarity_low[i];
                    end
                end
                MODE_ON:
                begin
                    pin_next[sel] = ~cfg.polarity_low[sel];
                end
                MODE_OFF:
                begin
                    pin_next[sel] = cfg.polarity_low[sel];
                end
                MODE_BLINK:
                begin
                    if (toggle_reg[sel] < toggle_limit)
                    begin
                        if (tick_reg[sel] == '0)
                        begin
                            tick_next[sel]   = PERIOD_W'(1);
                            toggle_next[sel] = toggle_reg[sel] + TOGGLE_W'(1);
                            phase_next[sel]  = ~phase_reg[sel];
                            pin_next[sel]    = ~phase_reg[sel] ^ cfg.polarity_low[sel];
                        end
                        else if (tick_reg[sel] < cfg.period[sel])
                        begin
                            tick_next[sel] = tick_reg[sel] + PERIOD_W'(1);
                        end
                        else
                        begin
                            tick_next[sel] = '0;
                        end
                    end
                end
                default:
                begin
                    status = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= '0;
            toggle_reg <= '0;
            phase_reg  <= '0;
            pin_reg    <= '0;
        end
        else if (step_fire)
        begin
            tick_reg   <= tick_next;
            toggle_reg <= toggle_next;
            phase_reg  <= phase_next;
            pin_reg    <= pin_next;
        end
    end

    assign result.status     = status;
    assign result.pin_levels = pin_next;

`ifndef NO_ASSERTIONS
    a_pins_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step_fire |=> $stable(pin_reg))
        else $error("pin register changed without a word");

    a_blink_state_only_on_blink: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && req.mode != MODE_BLINK |=>
            $stable(tick_reg) && $stable(toggle_reg) && $stable(phase_reg))
        else $error("blink state changed by a non-blink word");

    a_bad_index_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && req.mode != MODE_INIT && bad_index |=>
            $stable(pin_reg) && $stable(tick_reg) && $stable(toggle_reg))
        else $error("bad index word changed state");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/led_blink_controller_unit.sv =====
// LED blink controller, up to four LEDs with per-LED polarity and blink timer.
// Request channel (req): mode, led_index, blink_times; one word per request.
//   mode init drives every LED off, on/off set one LED, blink is one timer tick.
// Response channel (rsp): status (1 = bad LED index) and the pin levels after
//   the request, exactly one word per request, in order.
// Configuration: cfg_we/cfg_index/cfg_data write polarity (index 0) and the
//   per-LED periods (indexes 1 to 4); write only while no request is in flight.
// Path: an accepted request waits in the request register; once the response
//   register is free or being taken, one compare and increment on the named
//   LED updates the state and the result goes into the response register.
// Throughput: one request per cycle, sustained while rsp.ready stays high.
// Reset: pins, counters and phases clear, polarity clears, periods go to 1000.
// Stall: while rsp is held, one further request is taken into the request
//   register and then req.ready drops until the response word is taken.
`default_nettype none

module led_blink_controller_unit
    import lbc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    lbc_req_if.sink                     req,
    lbc_rsp_if.source                   rsp,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    cfg_t   cfg;
    req_t   req_word;
    rsp_t   step_result;
    logic   in_valid_reg;
    logic   in_valid_next;
    req_t   in_word_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    rsp_t   out_word_reg;
    logic   advance;
    logic   step_fire;
    logic   req_fire;

    lbc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lbc_led_core u_led_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_fire (step_fire),
        .req       (in_word_reg),
        .cfg       (cfg),
        .result    (step_result)
    );

    assign req_word.mode        = req.mode;
    assign req_word.led_index   = req.led_index;
    assign req_word.blink_times = req.blink_times;

    assign advance   = !out_valid_reg || rsp.ready;
    assign step_fire = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            in_word_reg <= req_word;
        end
        if (step_fire)
        begin
            out_word_reg <= step_result;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_word_reg.status;
    assign rsp.pin_levels = out_word_reg.pin_levels;

`ifndef NO_ASSERTIONS
    a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_word_reg))
        else $error("pending request word lost during response stall");
`endif

endmodule

`default_nettype wire

// ===== tb/led_blink_controller_unit_test.sv =====
`default_nettype none

module led_blink_controller_unit_test;
    import lbc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_WORDS  = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    lbc_req_if req ();
    lbc_rsp_if rsp ();

    led_blink_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted block state
    logic [POL_W-1:0]    pol_mask;
    logic [PERIOD_W-1:0] led_period [LEDS];
    logic [PERIOD_W-1:0] tick_count [LEDS];
    logic [TOGGLE_W-1:0] toggles    [LEDS];
    logic                phase      [LEDS];
    logic [PIN_W-1:0]    pins;

    rsp_t awaited_words [$];
    int   mismatches = 0;
    int   cycle_count = 0;
    int   rsp_hold = 0;
    bit   steady_send = 1'b0;
    bit   steady_take = 1'b0;

    function automatic void clear_led_state();
        pol_mask = '0;
        pins     = '0;
        for (int i = 0; i < LEDS; i++)
        begin
            led_period[i] = PERIOD_RESET;
            tick_count[i] = '0;
            toggles[i]    = '0;
            phase[i]      = 1'b0;
        end
    endfunction

    function automatic rsp_t serve_led_request(input req_t w);
        rsp_t r;
        int   led;
        led      = int'(w.led_index);
        r.status = STATUS_OK;
        if (w.mode == MODE_INIT)
        begin
            for (int i = 0; i < LEDS; i++)
                pins[i] = pol_mask[i];
        end
        else if (led >= LEDS)
            r.status = STATUS_BAD_INDEX;
        else if (w.mode == MODE_ON)
            pins[led] = ~pol_mask[led];
        else if (w.mode == MODE_OFF)
            pins[led] = pol_mask[led];
        else if (int'(toggles[led]) < 2 * int'(w.blink_times))
        begin
            if (tick_count[led] == '0)
            begin
                tick_count[led] = PERIOD_W'(1);
                toggles[led]    = toggles[led] + TOGGLE_W'(1);
                phase[led]      = ~phase[led];
                pins[led]       = phase[led] ^ pol_mask[led];
            end
            else if (tick_count[led] < led_period[led])
                tick_count[led] = tick_count[led] + PERIOD_W'(1);
            else
                tick_count[led] = '0;
        end
        r.pin_levels = pins;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 50)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what,
                     got, want);
        mismatches++;
    endtask

    // response check, then prediction of the word taken at this edge
    always @(posedge clk)
    begin
        rsp_t want;
        req_t w;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_words.size() == 0)
                    report_mismatch("unexpected response word", 1, 0);
                else
                begin
                    want = awaited_words.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", int'(rsp.status), int'(want.status));
                    if (rsp.pin_levels !== want.pin_levels)
                        report_mismatch("pin_levels", int'(rsp.pin_levels),
                                        int'(want.pin_levels));
                end
            end
            if (req.valid && req.ready)
            begin
                w.mode        = req.mode;
                w.led_index   = req.led_index;
                w.blink_times = req.blink_times;
                awaited_words.push_back(serve_led_request(w));
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_POLARITY)
                    pol_mask = cfg_data[POL_W-1:0];
                else if (cfg_index >= REG_PERIOD_BASE && cfg_index < REG_PERIOD_BASE + LEDS)
                    led_period[LED_IDX_W'(cfg_index - REG_PERIOD_BASE)] =
                        cfg_data[PERIOD_W-1:0];
            end
        end
    end

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, plus a long hold when asked
    initial
    begin
        int stall;
        stall     = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold > 0)
            begin
                stall    = rsp_hold;
                rsp_hold = 0;
            end
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                stall = pick_gap(steady_take);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("led_blink_controller_unit test failed");
        $finish;
    end

    task automatic send_word(input mode_t m, input logic [INDEX_W-1:0] idx,
                             input logic [TIMES_W-1:0] times);
        int gap;
        gap = pick_gap(steady_send);
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid       <= 1'b1;
        req.mode        <= m;
        req.led_index   <= idx;
        req.blink_times <= times;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic wait_all_words();
        @(negedge clk);
        req.valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic req_t random_request();
        req_t w;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 8)
            w.mode = MODE_INIT;
        else if (r < 22)
            w.mode = MODE_ON;
        else if (r < 36)
            w.mode = MODE_OFF;
        else
            w.mode = MODE_BLINK;
        if ($urandom_range(0, 99) < 88)
            w.led_index = INDEX_W'($urandom_range(0, LEDS - 1));
        else
            w.led_index = INDEX_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 30)
            w.blink_times = TIMES_W'($urandom_range(0, 3));
        else if (r < 70)
            w.blink_times = TIMES_W'($urandom_range(0, 100));
        else
            w.blink_times = TIMES_W'($urandom_range(0, 65535));
        return w;
    endfunction

    task automatic send_random_words(input int count);
        req_t w;
        repeat (count)
        begin
            w = random_request();
            send_word(w.mode, w.led_index, w.blink_times);
        end
    endtask

    task automatic test_basic_modes();
        send_word(MODE_INIT, 8'd255, 16'd0);
        for (int i = 0; i < LEDS; i++)
            send_word(MODE_ON, INDEX_W'(i), 16'hFFFF);
        send_word(MODE_OFF, 8'd2, 16'd0);
        send_word(MODE_ON, INDEX_W'(LEDS), 16'd0);
        send_word(MODE_OFF, 8'd255, 16'd0);
        send_word(MODE_BLINK, 8'd200, 16'd5);
        send_word(MODE_BLINK, 8'd0, 16'd0);
        send_word(MODE_BLINK, 8'd1, 16'hFFFF);
        send_word(MODE_BLINK, 8'd1, 16'hFFFF);
        send_word(MODE_INIT, 8'd0, 16'h5A5A);
        wait_all_words();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_POLARITY, CFG_W'(4'hF));
        write_reg(CFG_IDX_W'(int'(REG_PERIOD_BASE) + 0), CFG_W'(0));
        write_reg(CFG_IDX_W'(int'(REG_PERIOD_BASE) + 1), CFG_W'(1));
        write_reg(CFG_IDX_W'(int'(REG_PERIOD_BASE) + 2), {CFG_W{1'b1}});
        write_reg(CFG_IDX_W'(int'(REG_PERIOD_BASE) + 3), CFG_W'(2));
        write_reg(CFG_IDX_W'(7), CFG_W'(3));
        send_word(MODE_INIT, 8'd7, 16'd0);
        send_word(MODE_ON, 8'd3, 16'd0);
        // zero period, two blinks, then finished
        repeat (10) send_word(MODE_BLINK, 8'd0, 16'd2);
        send_word(MODE_BLINK, 8'd1, 16'd1);
        send_word(MODE_BLINK, 8'd2, 16'd1);
        send_word(MODE_BLINK, 8'd2, 16'd1);
        send_word(MODE_OFF, 8'd3, 16'd0);
        wait_all_words();
        write_reg(REG_POLARITY, CFG_W'(4'h5));
        send_word(MODE_INIT, 8'd0, 16'd0);
        wait_all_words();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_POLARITY, CFG_W'($urandom_range(0, 15)));
            for (int i = 0; i < LEDS; i++)
            begin
                case (p)
                    1:       write_reg(CFG_IDX_W'(int'(REG_PERIOD_BASE) + i),
                                       ($urandom_range(0, 2) == 0) ?
                                       {CFG_W{1'b1}} : CFG_W'($urandom_range(0, 1)));
                    2:       write_reg(CFG_IDX_W'(int'(REG_PERIOD_BASE) + i),
                                       CFG_W'($urandom_range(0, 10)));
                    default: write_reg(CFG_IDX_W'(int'(REG_PERIOD_BASE) + i),
                                       CFG_W'($urandom_range(0, 3)));
                endcase
            end
            steady_send = (p == 3);
            steady_take = (p == 3);
            send_random_words(PHASE_WORDS);
            wait_all_words();
        end
        steady_send = 1'b0;
        steady_take = 1'b0;
    endtask

    task automatic test_backpressure();
        steady_send = 1'b1;
        rsp_hold    = 200;
        send_random_words(40);
        steady_send = 1'b0;
        wait_all_words();
        send_random_words(20);
        wait_all_words();
    endtask

    initial
    begin
        req.valid       = 1'b0;
        req.mode        = MODE_INIT;
        req.led_index   = '0;
        req.blink_times = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        clear_led_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_modes();
        test_config_extremes();
        test_random_phases();
        test_backpressure();

        wait_all_words();
        if (mismatches == 0)
            $display("led_blink_controller_unit test passed");
        else
            $display("led_blink_controller_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/lbc_pkg.sv
rtl/core/lbc_req_if.sv
rtl/core/lbc_rsp_if.sv
rtl/core/lbc_cfg_regs.sv
rtl/core/lbc_led_core.sv
rtl/core/led_blink_controller_unit.sv
tb/led_blink_controller_unit_test.sv
